>>> rtl/adsr_envelope_amplifier_defines.svh
// Assertion macros used by the envelope amplifier RTL.
`ifndef ADSR_ENVELOPE_AMPLIFIER_DEFINES_SVH
`define ADSR_ENVELOPE_AMPLIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Concurrent assertion on clk, switched off while rst_n is low.
`define ADSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on clk that also holds during reset.
`define ADSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ADSR_ASSERT(lbl, prop, msg)
`define ADSR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/adsr_env_pkg.sv
// Types and constants for the ADSR envelope amplifier.
package adsr_env_pkg;

    localparam int unsigned DATA_W = 24;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Q1.23 full scale (1.0).
    localparam logic [DATA_W-1:0] FULL_SCALE = 24'd8388608;

    // Input item kinds carried in tuser.
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NOTE_ON = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 2'd3;

    // Configuration reset values.
    localparam logic [DATA_W-1:0] ATTACK_STEP_RST = 24'd19022;
    localparam logic [DATA_W-1:0] DECAY_STEP_RST = 24'd571;
    localparam logic [DATA_W-1:0] SUSTAIN_LEVEL_RST = 24'd5872026;
    localparam logic [DATA_W-1:0] RELEASE_STEP_RST = 24'd666;

    // Envelope stages.
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } stage_t;

    // Configuration register set.
    typedef struct packed {
        logic [DATA_W-1:0] attack_step;
        logic [DATA_W-1:0] decay_step;
        logic [DATA_W-1:0] sustain_level;
        logic [DATA_W-1:0] release_step;
    } cfg_t;

    // Sample and applied level handed to the multiplier stage.
    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic [DATA_W-1:0]        level;
    } vca_item_t;

endpackage

>>> rtl/adsr_envelope_amplifier.sv
// Top level of the linear ADSR envelope amplifier.
//
// A stream of note-on, note-off and audio-sample transactions enters on the slave
// side; each audio sample leaves on the master side scaled by the envelope level
// (Q1.23, floor shift by 23) together with the level applied. Note events give no
// output. One transaction is accepted every clock cycle when the output side keeps
// up; the envelope step and clamp are done at acceptance, so consecutive samples
// chain without bubbles. An accepted sample is first held in the stage machine's
// pipeline register, then passes the 24 x 24 multiplier into the output register.
// Configuration writes are taken every cycle and should be made only while no
// sample is in flight.
module adsr_envelope_amplifier
    import adsr_env_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [23:0] sample_in
    input  logic [1:0]           s_tuser,   // [1:0] mode
    // Output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // [23:0] sample_out, [47:24] level_out
    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    cfg_t                     cfg;
    logic                     item_valid;
    logic                     item_ready;
    vca_item_t                item;
    logic signed [DATA_W-1:0] out_sample;
    logic [DATA_W-1:0]        out_level;

    adsr_env_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adsr_env_gen u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_sample  (s_tdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    adsr_env_vca u_vca (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (out_sample),
        .out_level  (out_level)
    );

    assign m_tdata = {out_level, out_sample};

endmodule

>>> rtl/adsr_env_regs.sv
// Configuration register file of the ADSR envelope amplifier.
module adsr_env_regs
    import adsr_env_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are taken in any cycle.
    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    // Register decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ATTACK_STEP:   cfg_next.attack_step = cfg_data;
                REG_DECAY_STEP:    cfg_next.decay_step = cfg_data;
                REG_SUSTAIN_LEVEL: cfg_next.sustain_level = cfg_data;
                REG_RELEASE_STEP:  cfg_next.release_step = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_step <= ATTACK_STEP_RST;
            cfg_reg.decay_step <= DECAY_STEP_RST;
            cfg_reg.sustain_level <= SUSTAIN_LEVEL_RST;
            cfg_reg.release_step <= RELEASE_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/adsr_env_gen.sv
// Envelope stage machine and level stepping, with the input pipeline register.
`include "adsr_envelope_amplifier_defines.svh"

module adsr_env_gen
    import adsr_env_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MODE_W-1:0] in_mode,
    input  logic [DATA_W-1:0] in_sample,
    output logic              item_valid,
    input  logic              item_ready,
    output vca_item_t         item
);

    stage_t            stage_reg;
    stage_t            stage_next;
    logic [DATA_W-1:0] level_reg;
    logic [DATA_W-1:0] level_next;
    logic [DATA_W-1:0] applied;
    logic              item_valid_reg;
    logic              item_valid_next;
    vca_item_t         item_reg;

    logic              accept;
    logic              take_sample;
    logic [DATA_W-1:0] sus;
    logic [DATA_W:0]   att_sum;
    logic signed [DATA_W+1:0] dec_diff;
    logic signed [DATA_W+1:0] rel_diff;
    logic              att_full;
    logic              dec_hit;
    logic              rel_hit;

    // A new transaction is taken whenever the pipeline register is free or drains.
    assign in_ready = !item_valid_reg || item_ready;
    assign accept = in_valid && in_ready;
    assign take_sample = accept && (in_mode == MODE_SAMPLE);

    // Sustain above full scale saturates.
    assign sus = (cfg.sustain_level > FULL_SCALE) ? FULL_SCALE : cfg.sustain_level;

    // Stage step arithmetic and clamp tests.
    assign att_sum = {1'b0, level_reg} + {1'b0, cfg.attack_step};
    assign dec_diff = $signed({2'b00, level_reg}) - $signed({2'b00, cfg.decay_step});
    assign rel_diff = $signed({2'b00, level_reg}) - $signed({2'b00, cfg.release_step});
    assign att_full = (att_sum >= {1'b0, FULL_SCALE});
    assign dec_hit = (dec_diff <= $signed({2'b00, sus}));
    assign rel_hit = (rel_diff <= $signed({(DATA_W+2){1'b0}}));

    // Next stage.
    always_comb
    begin
        stage_next = stage_reg;
        if (accept)
        begin
            if (in_mode == MODE_NOTE_ON)
            begin
                stage_next = ST_ATTACK;
            end
            else if (in_mode == MODE_NOTE_OFF)
            begin
                stage_next = ST_RELEASE;
            end
            else if (in_mode == MODE_SAMPLE)
            begin
                unique case (stage_reg)
                    ST_ATTACK:  stage_next = att_full ? ST_DECAY : ST_ATTACK;
                    ST_DECAY:   stage_next = dec_hit ? ST_SUSTAIN : ST_DECAY;
                    ST_SUSTAIN: stage_next = ST_SUSTAIN;
                    ST_RELEASE: stage_next = rel_hit ? ST_IDLE : ST_RELEASE;
                    ST_IDLE:    stage_next = ST_IDLE;
                    default:    stage_next = ST_IDLE;
                endcase
            end
        end
    end

    // Level applied to the current sample.
    always_comb
    begin
        unique case (stage_reg)
            ST_ATTACK:  applied = att_full ? FULL_SCALE : att_sum[DATA_W-1:0];
            ST_DECAY:   applied = dec_hit ? sus : dec_diff[DATA_W-1:0];
            ST_SUSTAIN: applied = sus;
            ST_RELEASE: applied = rel_hit ? '0 : rel_diff[DATA_W-1:0];
            ST_IDLE:    applied = '0;
            default:    applied = '0;
        endcase
    end

    // Stored level: note-on clears it, a sample outside idle stores the applied level; idle samples leave it untouched.
    always_comb
    begin
        level_next = level_reg;
        if (accept && (in_mode == MODE_NOTE_ON))
        begin
            level_next = '0;
        end
        else if (take_sample && (stage_reg != ST_IDLE))
        begin
            level_next = applied;
        end
    end

    assign item_valid_next = take_sample ? 1'b1 : (item_ready ? 1'b0 : item_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_IDLE;
            level_reg <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            level_reg <= level_next;
            item_valid_reg <= item_valid_next;
        end
    end

    // Payload of the pipeline register.
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            item_reg.sample <= $signed(in_sample);
            item_reg.level <= applied;
        end
    end

    assign item_valid = item_valid_reg;
    assign item = item_reg;

    `ADSR_ASSERT(a_level_in_range, level_reg <= FULL_SCALE, "envelope level above full scale")
    `ADSR_ASSERT(a_attack_peak, (stage_reg == ST_DECAY && $past(stage_reg) == ST_ATTACK) |-> level_reg == FULL_SCALE, "attack ended below full scale")
    `ADSR_ASSERT(a_release_floor, (stage_reg == ST_IDLE && $past(stage_reg) == ST_RELEASE) |-> level_reg == '0, "release ended above zero")
    `ADSR_ASSERT(a_stage_hold, (!accept) |=> (stage_reg == $past(stage_reg) && level_reg == $past(level_reg)), "envelope moved without a transaction")

endmodule

>>> rtl/adsr_env_vca.sv
// Sample-by-level multiplier and the output register.
module adsr_env_vca
    import adsr_env_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  vca_item_t            item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [DATA_W-1:0] out_sample,
    output logic [DATA_W-1:0]    out_level
);

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] sample_reg;
    logic [DATA_W-1:0]        level_reg;
    logic signed [2*DATA_W:0] product;

    assign item_ready = !out_valid_reg || out_ready;

    // Q1.23 product, floor shift by 23.
    assign product = item.sample * $signed({1'b0, item.level});

    assign out_valid_next = item_valid ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            sample_reg <= product[2*DATA_W-2:DATA_W-1];
            level_reg <= item.level;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sample = sample_reg;
    assign out_level = level_reg;

endmodule
